FILE: src/ardd_pkg.sv
// Package: shared types and constants of the audio rip defect detector.
`default_nettype none

package ardd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EIGHT_BIT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_GUARD_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POP_LEVEL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_LEVEL       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUPE_RUN_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_MS         = 3'd6;

    // Register reset values
    localparam logic        RST_EIGHT_BIT_MODE   = 1'b0;
    localparam logic [3:0]  RST_SAMPLES_PER_STEP = 4'd2;
    localparam logic [31:0] RST_END_GUARD_MS     = 32'hFFFF_FFFF;
    localparam logic [14:0] RST_POP_LEVEL        = 15'd10000;
    localparam logic [14:0] RST_DROP_LEVEL       = 15'd20000;
    localparam logic [15:0] RST_DUPE_RUN_MIN     = 16'd400;
    localparam logic [15:0] RST_GUARD_MS         = 16'd5000;

    // Timing and detection constants
    localparam logic [15:0]        MS_PER_STEP    = 16'd2000;
    localparam logic [15:0]        RATE_HZ        = 16'd44100;
    localparam logic [7:0]         MIN_STEPS      = 8'd12;
    localparam logic [7:0]         DROP_SPACING   = 8'd8;
    localparam logic signed [16:0] SMALL_MAG      = 17'sd10;
    localparam logic [8:0]         EIGHT_BIT_BIAS = 9'd128;
    localparam logic [3:0]         STEP_MIN       = 4'd1;
    localparam logic [3:0]         STEP_MAX       = 4'd8;

    typedef struct packed {
        logic        eight_bit_mode;
        logic [3:0]  samples_per_step;
        logic [31:0] end_guard_ms;
        logic [14:0] pop_level;
        logic [14:0] drop_level;
        logic [15:0] dupe_run_min;
        logic [15:0] guard_ms;
    } cfg_t;

    // Converted sample plus its own classification
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       drop_hi;
        logic                       drop_lo;
        logic                       big;
    } item_t;

    typedef struct packed {
        logic                       pop_flag;
        logic                       drop_flag;
        logic                       dupe_flag;
        logic [32:0]                sample_position;
        logic [31:0]                time_ms;
        logic [31:0]                run_length;
        logic signed [SAMPLE_W-1:0] signed_value;
        logic [31:0]                defect_total;
        logic                       all_clear;
    } result_t;

endpackage

`default_nettype wire

FILE: src/ardd_front.sv
// Front end: sample conversion and per-sample classification.
`default_nettype none

module ardd_front
    import ardd_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0] raw_sample,
    input  wire logic                eight_bit_mode,
    input  wire logic [14:0]         drop_level,
    output      item_t               item
);

    logic [8:0]         byte_off;
    logic signed [15:0] x;
    logic signed [16:0] x_ext;
    logic signed [16:0] dlev;

    always_comb
    begin
        byte_off = {1'b0, raw_sample[7:0]} - EIGHT_BIT_BIAS;
        if (eight_bit_mode)
        begin
            x = {{7{byte_off[8]}}, byte_off};
        end
        else
        begin
            x = raw_sample;
        end
        x_ext = {x[15], x};
        dlev  = {2'b00, drop_level};

        item.value   = x;
        item.drop_hi = x_ext > dlev;
        item.drop_lo = x_ext < -dlev;
        item.big     = (x_ext >= SMALL_MAG) || (x_ext <= -SMALL_MAG);
    end

endmodule

`default_nettype wire

FILE: src/ardd_queue.sv
// Two-entry queue between front end and back end.
`default_nettype none

module ardd_queue
    import ardd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output      logic  push_ready,
    input  wire item_t push_item,
    output      logic  pop_valid,
    input  wire logic  pop_ready,
    output      item_t pop_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // occupancy never beyond two
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");

endmodule

`default_nettype wire

FILE: src/ardd_back.sv
// Back end: history, counters, defect checks and result register.
`default_nettype none

module ardd_back
    import ardd_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    in_valid,
    output      logic    in_ready,
    input  wire item_t   item,
    output      logic    out_valid,
    input  wire logic    out_ready,
    output      result_t result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic signed [15:0]    hist_reg [6];
    logic [COUNT_BITS-1:0] repeat_run_reg, repeat_run_next;
    logic [COUNT_BITS-1:0] step_count_reg, step_count_next;
    logic [2:0]            slot_reg, slot_next;
    logic [15:0]           ms_fraction_reg, ms_fraction_next;
    logic [31:0]           ms_count_reg, ms_count_next;
    logic [COUNT_BITS-1:0] last_pop_step_reg, last_pop_step_next;
    logic [31:0]           last_dupe_ms_reg, last_dupe_ms_next;
    logic [COUNT_BITS-1:0] defect_count_reg, defect_count_next;
    logic                  out_valid_reg;
    result_t               result_reg, result_next;

    logic                  fire;
    logic                  past_start, in_time, far_from_pop;
    logic                  pop, drop, dupe, same;
    logic signed [16:0]    x2_ext, plev, dlev;
    logic [COUNT_BITS:0]   pop_gap;
    logic [32:0]           dupe_limit;
    logic [COUNT_BITS:0]   defect_sum;
    logic [1:0]            defect_inc;
    logic [3:0]            sps_eff, slot_inc;
    logic                  step_done;
    logic [15:0]           frac_sum;
    logic [COUNT_BITS+33:0] pos_ext;
    logic [COUNT_BITS+31:0] run_ext;
    logic [COUNT_BITS+31:0] total_ext;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Defect checks
    always_comb
    begin
        past_start = step_count_reg > COUNT_BITS'(MIN_STEPS);
        in_time    = ms_count_reg < cfg.end_guard_ms;
        x2_ext     = {hist_reg[1][15], hist_reg[1]};
        plev       = {2'b00, cfg.pop_level};
        dlev       = {2'b00, cfg.drop_level};

        pop = (hist_reg[5] == 16'sd0) && (hist_reg[4] == 16'sd0) &&
              (hist_reg[3] == 16'sd0) && (hist_reg[2] == 16'sd0) &&
              ((x2_ext > plev) || (x2_ext < -plev)) && past_start && in_time;

        // a pop or drop in this item moves the last-pop mark onto the current step
        pop_gap      = {1'b0, step_count_reg} - {1'b0, last_pop_step_reg};
        far_from_pop = !pop && !pop_gap[COUNT_BITS] &&
                       (pop_gap[COUNT_BITS-1:0] > COUNT_BITS'(DROP_SPACING));

        drop = (hist_reg[0] == 16'sd0) &&
               (((x2_ext > dlev) && item.drop_hi) || ((x2_ext < -dlev) && item.drop_lo)) &&
               past_start && far_from_pop && in_time;

        same       = hist_reg[0] == item.value;
        dupe_limit = {1'b0, last_dupe_ms_reg} + {17'd0, cfg.guard_ms};
        dupe = !same && item.big && (repeat_run_reg > COUNT_BITS'(cfg.dupe_run_min)) &&
               (ms_count_reg > {16'd0, cfg.guard_ms}) && in_time &&
               ({1'b0, ms_count_reg} > dupe_limit);
    end

    // Next state and result
    always_comb
    begin
        if (same)
        begin
            repeat_run_next = (repeat_run_reg != CNT_MAX) ?
                              repeat_run_reg + CNT_ONE : repeat_run_reg;
        end
        else
        begin
            repeat_run_next = '0;
        end

        defect_inc = {1'b0, pop} + {1'b0, drop} + {1'b0, dupe};
        defect_sum = {1'b0, defect_count_reg} + {{(COUNT_BITS-1){1'b0}}, defect_inc};
        defect_count_next = defect_sum[COUNT_BITS] ? CNT_MAX : defect_sum[COUNT_BITS-1:0];

        last_pop_step_next = (pop || drop) ? step_count_reg : last_pop_step_reg;
        last_dupe_ms_next  = dupe ? ms_count_reg : last_dupe_ms_reg;

        // step and millisecond counters
        sps_eff = cfg.samples_per_step;
        if (sps_eff == 4'd0)
        begin
            sps_eff = STEP_MIN;
        end
        else if (sps_eff > STEP_MAX)
        begin
            sps_eff = STEP_MAX;
        end
        slot_inc  = {1'b0, slot_reg} + 4'd1;
        step_done = slot_inc >= sps_eff;
        slot_next = step_done ? 3'd0 : slot_inc[2:0];

        step_count_next  = step_count_reg;
        ms_fraction_next = ms_fraction_reg;
        ms_count_next    = ms_count_reg;
        frac_sum         = ms_fraction_reg + MS_PER_STEP;
        if (step_done && (step_count_reg != CNT_MAX))
        begin
            step_count_next = step_count_reg + CNT_ONE;
            if (frac_sum >= RATE_HZ)
            begin
                ms_fraction_next = frac_sum - RATE_HZ;
                if (ms_count_reg != 32'hFFFF_FFFF)
                begin
                    ms_count_next = ms_count_reg + 32'd1;
                end
            end
            else
            begin
                ms_fraction_next = frac_sum;
            end
        end

        pos_ext   = {33'd0, step_count_reg, 1'b0};
        run_ext   = {32'd0, repeat_run_reg};
        total_ext = {32'd0, defect_count_next};

        result_next.pop_flag        = pop;
        result_next.drop_flag       = drop;
        result_next.dupe_flag       = dupe;
        result_next.sample_position = pos_ext[32:0];
        result_next.time_ms         = ms_count_reg;
        result_next.run_length      = dupe ? run_ext[31:0] : 32'd0;
        result_next.signed_value    = item.value;
        result_next.defect_total    = total_ext[31:0];
        result_next.all_clear       = defect_count_next == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                hist_reg[i] <= 16'sd0;
            end
            repeat_run_reg    <= '0;
            step_count_reg    <= '0;
            slot_reg          <= 3'd0;
            ms_fraction_reg   <= 16'd0;
            ms_count_reg      <= 32'd0;
            last_pop_step_reg <= '0;
            last_dupe_ms_reg  <= 32'd0;
            defect_count_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                for (int i = 5; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0]       <= item.value;
                repeat_run_reg    <= repeat_run_next;
                step_count_reg    <= step_count_next;
                slot_reg          <= slot_next;
                ms_fraction_reg   <= ms_fraction_next;
                ms_count_reg      <= ms_count_next;
                last_pop_step_reg <= last_pop_step_next;
                last_dupe_ms_reg  <= last_dupe_ms_next;
                defect_count_reg  <= defect_count_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_fraction_reg < RATE_HZ)
        else $error("ms fraction out of range");

    a_pop_mark: assert property (@(posedge clk) disable iff (!rst_n)
        last_pop_step_reg <= step_count_reg)
        else $error("last pop mark ahead of step count");

    a_pop_excl_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.pop_flag |-> !result_reg.drop_flag)
        else $error("pop and drop reported on one sample");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(step_count_reg) && $stable(defect_count_reg))
        else $error("counters moved without a transfer");

endmodule

`default_nettype wire

FILE: src/audio_rip_defect_detector_top.sv
// Top level: audio rip defect detector with configuration registers.
//
// Usage:
//   Input channel (in_valid/in_ready, raw_sample) carries one audio sample per
//   transfer. Output channel (out_valid/out_ready) carries one result per
//   input sample: pop/drop/dupe flags, position, time in ms, run length,
//   converted sample, running defect total and the all-clear flag.
//   Configuration: cfg_write_en, cfg_index, cfg_data write one register per
//   cycle; write only while no samples are in flight. Unknown indexes are
//   ignored.
// Result path: an accepted sample is queued, then the back end registers its
//   result (out_valid high from then on until the result transfer completes).
// Throughput: one sample per clock, sustained while out_ready is high. The
//   back end retires one item per cycle, updating history and counters.
// Stall: when out_ready is low with a result pending the result register
//   holds; the two-entry queue between front and back end keeps taking
//   samples until it is full, then in_ready drops.
// Reset: history clears to zero, all counters clear, registers return to
//   their defaults; no clearing pass.
`default_nettype none

module audio_rip_defect_detector_top
    import ardd_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // sample input
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [SAMPLE_W-1:0]   raw_sample,
    // result output
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic                  pop_flag,
    output      logic                  drop_flag,
    output      logic                  dupe_flag,
    output      logic [32:0]           sample_position,
    output      logic [31:0]           time_ms,
    output      logic [31:0]           run_length,
    output      logic signed [15:0]    signed_value,
    output      logic [31:0]           defect_total,
    output      logic                  all_clear
);

    cfg_t    cfg_reg, cfg_next;
    item_t   front_item, queue_item;
    logic    queue_valid, back_ready;
    result_t result;

    // Register file write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_EIGHT_BIT_MODE:   cfg_next.eight_bit_mode   = cfg_data[0];
                REG_SAMPLES_PER_STEP: cfg_next.samples_per_step = cfg_data[3:0];
                REG_END_GUARD_MS:     cfg_next.end_guard_ms     = cfg_data[31:0];
                REG_POP_LEVEL:        cfg_next.pop_level        = cfg_data[14:0];
                REG_DROP_LEVEL:       cfg_next.drop_level       = cfg_data[14:0];
                REG_DUPE_RUN_MIN:     cfg_next.dupe_run_min     = cfg_data[15:0];
                REG_GUARD_MS:         cfg_next.guard_ms         = cfg_data[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eight_bit_mode   <= RST_EIGHT_BIT_MODE;
            cfg_reg.samples_per_step <= RST_SAMPLES_PER_STEP;
            cfg_reg.end_guard_ms     <= RST_END_GUARD_MS;
            cfg_reg.pop_level        <= RST_POP_LEVEL;
            cfg_reg.drop_level       <= RST_DROP_LEVEL;
            cfg_reg.dupe_run_min     <= RST_DUPE_RUN_MIN;
            cfg_reg.guard_ms         <= RST_GUARD_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: convert and classify the incoming sample
    ardd_front u_front (
        .raw_sample     (raw_sample),
        .eight_bit_mode (cfg_reg.eight_bit_mode),
        .drop_level     (cfg_reg.drop_level),
        .item           (front_item)
    );

    // Decoupling queue; its free space sets in_ready
    ardd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_item   (queue_item)
    );

    // Back end: history, counters, checks, result register
    ardd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .item      (queue_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign pop_flag        = result.pop_flag;
    assign drop_flag       = result.drop_flag;
    assign dupe_flag       = result.dupe_flag;
    assign sample_position = result.sample_position;
    assign time_ms         = result.time_ms;
    assign run_length      = result.run_length;
    assign signed_value    = result.signed_value;
    assign defect_total    = result.defect_total;
    assign all_clear       = result.all_clear;

endmodule

`default_nettype wire
